// ----- hw/rtl/pngse_pkg.sv -----
package pngse_pkg;

  localparam int BLOCK_MAX_DEF = 65535;
  localparam int MAX_DIM_DEF   = 8192;

  localparam int DIM_W  = 14;
  localparam int CFG_IW = 8;

  localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CFG_IW-1:0] CFG_IMAGE_HEIGHT = 8'd1;

  localparam logic [31:0] TAG_IHDR = 32'h49484452;
  localparam logic [31:0] TAG_IDAT = 32'h49444154;
  localparam logic [31:0] TAG_IEND = 32'h49454E44;
  localparam logic [31:0] IHDR_LEN = 32'd13;
  localparam logic [7:0]  ZLIB_CMF = 8'h78;
  localparam logic [7:0]  ZLIB_FLG = 8'h01;
  localparam logic [7:0]  BIT_DEPTH  = 8'd8;
  localparam logic [7:0]  COLOR_TYPE = 8'd6;

  typedef enum logic [3:0] {
    SEL_SIG,
    SEL_LEN13,
    SEL_TAG_IHDR,
    SEL_TAG_IDAT,
    SEL_TAG_IEND,
    SEL_WIDTH,
    SEL_HEIGHT,
    SEL_IHDR_TAIL,
    SEL_CRC,
    SEL_IDAT_LEN,
    SEL_ZLIB,
    SEL_BHDR,
    SEL_FILTER,
    SEL_PIXEL,
    SEL_ADLER,
    SEL_ZERO
  } sel_e;

  typedef struct packed {
    logic       emit;
    sel_e       sel;
    logic [2:0] idx;
    logic       crc_en;
    logic       crc_clr;
    logic       run_last;
    logic       file_end;
    logic       raw_en;
    logic       load_block;
    logic       pixel_done;
    logic       start;
    logic       pix_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_done;
    logic row_start;
    logic blk_empty;
    logic img_end;
  } stat_t;

  // big-endian byte of a word, byte 0 is the most significant
  function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] i);
    logic [7:0] b;
    case (i)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [7:0] sig_byte(input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = 8'd137;
      3'd1:    b = 8'd80;
      3'd2:    b = 8'd78;
      3'd3:    b = 8'd71;
      3'd4:    b = 8'd13;
      3'd5:    b = 8'd10;
      3'd6:    b = 8'd26;
      default: b = 8'd10;
    endcase
    return b;
  endfunction

endpackage

// ----- hw/rtl/pngse_dp.sv -----
module pngse_dp #(
  parameter int StoredBlockMax = pngse_pkg::BLOCK_MAX_DEF,
  parameter int MaxDim         = pngse_pkg::MAX_DIM_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [pngse_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [pngse_pkg::DIM_W-1:0]  cfg_data_i,
  input  logic [7:0]                 pixel_byte_i,
  input  pngse_pkg::cmd_t            cmd_i,
  output pngse_pkg::stat_t           stat_o,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic [7:0]                 out_byte_o,
  output logic                       run_last_o,
  output logic                       file_end_o
);
  import pngse_pkg::*;

  localparam int Blk    = (StoredBlockMax < 2) ? 2 : StoredBlockMax;
  localparam int DimCap = (MaxDim < 16383) ? MaxDim : 16383;
  localparam logic [DIM_W-1:0] DIM_CAP = DimCap[DIM_W-1:0];
  localparam logic [16:0] BLK17 = Blk[16:0];
  localparam int RAW_W = 30;
  localparam int NUM_W = RAW_W;
  localparam logic [NUM_W-1:0] BLK_M1 = NUM_W'(Blk - 1);
  localparam logic [15:0] ADLER_MOD = 16'd65521;
  // block count as (raw + Blk - 1) * ceil(2^SH / Blk) >> SH, exact for 30-bit numerators
  localparam int BLK_L  = $clog2(Blk);
  localparam int SH     = NUM_W + BLK_L;
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(Blk) - 64'd1) / 64'(Blk);
  localparam int RCP_W  = NUM_W + 1;
  localparam logic [RCP_W-1:0] RCP = RECIP[RCP_W-1:0];
  localparam int PROD_W = NUM_W + RCP_W;

  typedef enum logic [2:0] {DV_IDLE, DV_MUL, DV_LOAD, DV_DIV, DV_SUM, DV_DONE} dv_e;

  logic [DIM_W-1:0] width_q, height_q, lat_w_q, lat_h_q;
  logic [7:0]       pix_q;
  dv_e              dv_q;
  logic [RAW_W-1:0] raw_q, raw_rem_q;
  logic [NUM_W-1:0] num_q, quo_q;
  logic [31:0]      idat_len_q, crc_q;
  logic [15:0]      blk_rem_q, adl_lo_q, adl_hi_q;
  logic [15:0]      rbc_q;
  logic [DIM_W-1:0] row_q;
  logic             out_valid_q, run_last_q, file_end_q;
  logic [7:0]       out_byte_q;

  function automatic logic [DIM_W-1:0] clamp(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_CAP) r = DIM_CAP;
    else r = v;
    return r;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
    return r;
  endfunction

  // block header fields
  logic        bfinal;
  logic [15:0] blk_n;
  assign bfinal = ({{(RAW_W-17){1'b0}}, BLK17} >= raw_rem_q);
  assign blk_n  = bfinal ? raw_rem_q[15:0] : BLK17[15:0];

  logic [PROD_W-1:0] prod;
  assign prod = PROD_W'(num_q) * PROD_W'(RCP);

  logic [7:0] byte_d, raw_b;
  logic [1:0] bi;
  assign bi    = cmd_i.idx[1:0];
  assign raw_b = (cmd_i.sel == SEL_PIXEL) ? pix_q : 8'd0;

  always_comb begin
    case (cmd_i.sel)
      SEL_SIG:       byte_d = sig_byte(cmd_i.idx);
      SEL_LEN13:     byte_d = be_byte(IHDR_LEN, bi);
      SEL_TAG_IHDR:  byte_d = be_byte(TAG_IHDR, bi);
      SEL_TAG_IDAT:  byte_d = be_byte(TAG_IDAT, bi);
      SEL_TAG_IEND:  byte_d = be_byte(TAG_IEND, bi);
      SEL_WIDTH:     byte_d = be_byte({18'd0, lat_w_q}, bi);
      SEL_HEIGHT:    byte_d = be_byte({18'd0, lat_h_q}, bi);
      SEL_IHDR_TAIL: byte_d = (cmd_i.idx == 3'd0) ? BIT_DEPTH :
                              (cmd_i.idx == 3'd1) ? COLOR_TYPE : 8'd0;
      SEL_CRC:       byte_d = be_byte(~crc_q, bi);
      SEL_IDAT_LEN:  byte_d = be_byte(idat_len_q, bi);
      SEL_ZLIB:      byte_d = (cmd_i.idx == 3'd0) ? ZLIB_CMF : ZLIB_FLG;
      SEL_BHDR: begin
        case (cmd_i.idx)
          3'd0:    byte_d = {7'd0, bfinal};
          3'd1:    byte_d = blk_n[7:0];
          3'd2:    byte_d = blk_n[15:8];
          3'd3:    byte_d = ~blk_n[7:0];
          default: byte_d = ~blk_n[15:8];
        endcase
      end
      SEL_FILTER:    byte_d = raw_b;
      SEL_PIXEL:     byte_d = raw_b;
      SEL_ADLER:     byte_d = be_byte({adl_hi_q, adl_lo_q}, bi);
      SEL_ZERO:      byte_d = 8'd0;
      default:       byte_d = 8'd0;
    endcase
  end

  logic [16:0] lo_sum, hi_sum;
  logic [15:0] lo_d, hi_d;
  assign lo_sum = {1'b0, adl_lo_q} + {9'd0, raw_b};
  assign lo_d   = (lo_sum >= {1'b0, ADLER_MOD}) ? 16'(lo_sum - {1'b0, ADLER_MOD}) : lo_sum[15:0];
  assign hi_sum = {1'b0, adl_hi_q} + {1'b0, lo_d};
  assign hi_d   = (hi_sum >= {1'b0, ADLER_MOD}) ? 16'(hi_sum - {1'b0, ADLER_MOD}) : hi_sum[15:0];

  logic row_end;
  assign row_end = (rbc_q == 16'({lat_w_q, 2'b00} - 16'd1));

  assign stat_o.out_free  = !out_valid_q || !out_stall_i;
  assign stat_o.div_done  = (dv_q == DV_DONE);
  assign stat_o.row_start = (rbc_q == '0);
  assign stat_o.blk_empty = (blk_rem_q == '0);
  assign stat_o.img_end   = row_end && (row_q == lat_h_q - DIM_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= DIM_W'(1);
      height_q    <= DIM_W'(1);
      lat_w_q     <= DIM_W'(1);
      lat_h_q     <= DIM_W'(1);
      dv_q        <= DV_IDLE;
      raw_q       <= '0;
      raw_rem_q   <= '0;
      num_q       <= '0;
      quo_q       <= '0;
      idat_len_q  <= '0;
      crc_q       <= '1;
      blk_rem_q   <= '0;
      adl_lo_q    <= 16'd1;
      adl_hi_q    <= '0;
      rbc_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_i == CFG_IMAGE_WIDTH)  width_q  <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == CFG_IMAGE_HEIGHT) height_q <= cfg_data_i;

      if (cmd_i.start) begin
        lat_w_q <= clamp(width_q);
        lat_h_q <= clamp(height_q);
        dv_q    <= DV_MUL;
      end

      // IDAT length: raw size, then block count by reciprocal multiplication
      case (dv_q)
        DV_MUL: begin
          raw_q     <= RAW_W'(lat_h_q * {lat_w_q, 2'b01});
          raw_rem_q <= RAW_W'(lat_h_q * {lat_w_q, 2'b01});
          dv_q      <= DV_LOAD;
        end
        DV_LOAD: begin
          num_q <= raw_q + BLK_M1;
          dv_q  <= DV_DIV;
        end
        DV_DIV: begin
          quo_q <= NUM_W'(prod >> SH);
          dv_q  <= DV_SUM;
        end
        DV_SUM: begin
          idat_len_q <= 32'd6 + {quo_q, 2'b00} + {2'b00, quo_q} + {2'b00, raw_q};
          dv_q       <= DV_DONE;
        end
        default: ;
      endcase

      if (cmd_i.emit) begin
        if (cmd_i.crc_en) crc_q <= crc_byte(crc_q, byte_d);
        else if (cmd_i.crc_clr) crc_q <= '1;
      end

      if (cmd_i.load_block) blk_rem_q <= blk_n;
      else if (cmd_i.raw_en && blk_rem_q != '0) blk_rem_q <= blk_rem_q - 16'd1;

      if (cmd_i.raw_en) begin
        adl_lo_q <= lo_d;
        adl_hi_q <= hi_d;
        if (raw_rem_q != '0) raw_rem_q <= raw_rem_q - RAW_W'(1);
      end

      if (cmd_i.pixel_done) begin
        if (row_end) begin
          rbc_q <= '0;
          row_q <= row_q + DIM_W'(1);
        end else begin
          rbc_q <= rbc_q + 16'd1;
        end
      end

      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_load) pix_q <= pixel_byte_i;
    if (cmd_i.emit) begin
      out_byte_q <= byte_d;
      run_last_q <= cmd_i.run_last;
      file_end_q <= cmd_i.file_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;
  assign file_end_o  = file_end_q;

endmodule

// ----- hw/rtl/pngse_ctrl.sv -----
module pngse_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pngse_pkg::stat_t stat_i,
  output pngse_pkg::cmd_t  cmd_o
);
  import pngse_pkg::*;

  typedef enum logic [4:0] {
    ST_START, ST_SIG, ST_IHDR_LEN, ST_IHDR_TAG, ST_WIDTH, ST_HEIGHT, ST_IHDR_TAIL,
    ST_IHDR_CRC, ST_IDAT_LEN, ST_IDAT_TAG, ST_ZLIB, ST_DATA, ST_BHDR, ST_IDLE,
    ST_ADLER, ST_IDAT_CRC, ST_IEND_LEN, ST_IEND_TAG, ST_IEND_CRC, ST_DONE
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] idx_q, idx_d;
  logic       filt_q, filt_d;

  logic       seq, crc, clr;
  sel_e       sel;
  logic [2:0] last;
  state_e     nxt;
  logic       fire, accept;

  assign in_stall_o = !(state_q == ST_START || state_q == ST_IDLE || state_q == ST_DONE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    seq  = 1'b1;
    crc  = 1'b1;
    clr  = 1'b0;
    sel  = SEL_ZERO;
    last = 3'd3;
    nxt  = state_q;
    case (state_q)
      ST_SIG:       begin sel = SEL_SIG; crc = 1'b0; last = 3'd7; nxt = ST_IHDR_LEN; end
      ST_IHDR_LEN:  begin sel = SEL_LEN13; crc = 1'b0; nxt = ST_IHDR_TAG; end
      ST_IHDR_TAG:  begin sel = SEL_TAG_IHDR; nxt = ST_WIDTH; end
      ST_WIDTH:     begin sel = SEL_WIDTH; nxt = ST_HEIGHT; end
      ST_HEIGHT:    begin sel = SEL_HEIGHT; nxt = ST_IHDR_TAIL; end
      ST_IHDR_TAIL: begin sel = SEL_IHDR_TAIL; last = 3'd4; nxt = ST_IHDR_CRC; end
      ST_IHDR_CRC:  begin sel = SEL_CRC; crc = 1'b0; clr = 1'b1; nxt = ST_IDAT_LEN; end
      ST_IDAT_LEN:  begin sel = SEL_IDAT_LEN; crc = 1'b0; nxt = ST_IDAT_TAG; end
      ST_IDAT_TAG:  begin sel = SEL_TAG_IDAT; nxt = ST_ZLIB; end
      ST_ZLIB:      begin sel = SEL_ZLIB; last = 3'd1; nxt = ST_DATA; end
      ST_BHDR:      begin sel = SEL_BHDR; last = 3'd4; nxt = ST_DATA; end
      ST_ADLER:     begin sel = SEL_ADLER; nxt = ST_IDAT_CRC; end
      ST_IDAT_CRC:  begin sel = SEL_CRC; crc = 1'b0; clr = 1'b1; nxt = ST_IEND_LEN; end
      ST_IEND_LEN:  begin sel = SEL_ZERO; crc = 1'b0; nxt = ST_IEND_TAG; end
      ST_IEND_TAG:  begin sel = SEL_TAG_IEND; nxt = ST_IEND_CRC; end
      ST_IEND_CRC:  begin sel = SEL_CRC; crc = 1'b0; clr = 1'b1; nxt = ST_DONE; end
      default:      seq = 1'b0;
    endcase
  end

  // the IDAT length waits for the block count
  assign fire = stat_i.out_free && (state_q != ST_IDAT_LEN || stat_i.div_done);

  always_comb begin
    cmd_o          = '0;
    cmd_o.sel      = sel;
    cmd_o.idx      = idx_q;
    cmd_o.pix_load = accept && state_q != ST_DONE;
    cmd_o.start    = accept && state_q == ST_START;
    state_d        = state_q;
    idx_d          = idx_q;
    filt_d         = filt_q;
    if (seq) begin
      if (fire) begin
        cmd_o.emit   = 1'b1;
        cmd_o.crc_en = crc;
        if (idx_q == last) begin
          idx_d             = '0;
          state_d           = nxt;
          cmd_o.crc_clr     = clr;
          cmd_o.load_block  = (state_q == ST_BHDR);
          cmd_o.run_last    = (state_q == ST_IEND_CRC);
          cmd_o.file_end    = (state_q == ST_IEND_CRC);
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
    end else begin
      case (state_q)
        ST_START: if (accept) state_d = ST_SIG;
        ST_IDLE:  if (accept) state_d = ST_DATA;
        ST_DATA: begin
          if (stat_i.blk_empty) begin
            state_d = ST_BHDR;
          end else if (stat_i.out_free) begin
            cmd_o.emit   = 1'b1;
            cmd_o.crc_en = 1'b1;
            cmd_o.raw_en = 1'b1;
            if (stat_i.row_start && !filt_q) begin
              cmd_o.sel = SEL_FILTER;
              filt_d    = 1'b1;
            end else begin
              cmd_o.sel        = SEL_PIXEL;
              cmd_o.pixel_done = 1'b1;
              filt_d           = 1'b0;
              if (stat_i.img_end) begin
                state_d = ST_ADLER;
              end else begin
                cmd_o.run_last = 1'b1;
                state_d        = ST_IDLE;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
      idx_q   <= '0;
      filt_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      filt_q  <= filt_d;
    end
  end

endmodule

// ----- hw/rtl/png_stored_block_encoder.sv -----
// PNG writer with stored zlib blocks: feed RGBA8 sample bytes top-down, one beat each, and
// read the complete PNG file as one byte per output beat. Output bytes come at most one a
// cycle while the output is not stalled, through a registered output port: an ordinary
// pixel byte is accepted, then its byte is sent; a row start adds the filter byte, a block
// start adds the stored-block header. The first item also sends the signature, IHDR and
// IDAT header (43 bytes); its IDAT length comes from a reciprocal multiply that runs
// through multiply, load, divide and sum steps once that item is taken, long before the
// header reaches it. The last item of the image adds the Adler-32, the IDAT CRC and IEND
// (20 bytes); file_end marks the last byte, run_last the last byte of each item. Width and
// height are sampled on the first item; bytes after the image are taken and dropped.
module png_stored_block_encoder #(
  parameter int StoredBlockMax = pngse_pkg::BLOCK_MAX_DEF,
  parameter int MaxDim         = pngse_pkg::MAX_DIM_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pngse_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [pngse_pkg::DIM_W-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   pixel_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   out_byte_o,
  output logic                         run_last_o,
  output logic                         file_end_o
);
  import pngse_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  pngse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pngse_dp #(
    .StoredBlockMax (StoredBlockMax),
    .MaxDim         (MaxDim)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_byte_i (pixel_byte_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .file_end_o   (file_end_o)
  );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import pngse_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       fin;
  } png_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IW-1:0] cfg_index_i = '0;
  logic [DIM_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] pixel_byte_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic run_last_o;
  logic file_end_o;

  png_stored_block_encoder dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // encoder state mirrored in the testbench
  localparam int BlkMax = BLOCK_MAX_DEF;
  typedef enum int {ENC_IDLE, ENC_STREAM, ENC_DONE} enc_phase_e;
  enc_phase_e enc_phase;
  int unsigned reg_w, reg_h, dim_w, dim_h, row_cnt, row_bytes, blk_left;
  longint unsigned raw_left;
  logic [31:0] crc_acc;
  int unsigned adl_lo, adl_hi;

  png_beat_t file_q[$];
  png_beat_t step_q[$];
  logic [7:0] pend_q[$];

  bit feed_en = 0;
  int unsigned n_in = 0, n_out = 0, n_bad = 0, n_total = 1;
  int unsigned idle_cnt = 0, hold_left = 0;
  bit held = 0;
  int unsigned tx_idle, rx_idle;

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v < 1) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return v;
  endfunction

  task automatic emit(input logic [7:0] b, input bit crc_on);
    png_beat_t e;
    if (crc_on) begin
      crc_acc ^= {24'd0, b};
      for (int k = 0; k < 8; k++)
        crc_acc = crc_acc[0] ? (crc_acc >> 1) ^ 32'hEDB88320 : crc_acc >> 1;
    end
    e.data = b; e.last = 0; e.fin = 0;
    step_q = {step_q, e};
  endtask

  task automatic emit32(input logic [31:0] v, input bit crc_on);
    for (int i = 3; i >= 0; i--) emit(v[8*i +: 8], crc_on);
  endtask

  task automatic emit_crc();
    emit32(~crc_acc, 0);
    crc_acc = '1;
  endtask

  task automatic emit_raw(input logic [7:0] b);
    int unsigned n;
    if (blk_left == 0) begin
      n = BlkMax;
      if (raw_left < n) n = 32'(raw_left);
      emit((n == raw_left) ? 8'd1 : 8'd0, 1);
      emit(n[7:0], 1);
      emit(n[15:8], 1);
      emit(~n[7:0], 1);
      emit(~n[15:8], 1);
      blk_left = n;
    end
    emit(b, 1);
    adl_lo = (adl_lo + b) % 65521;
    adl_hi = (adl_hi + adl_lo) % 65521;
    if (blk_left > 0) blk_left--;
    if (raw_left > 0) raw_left--;
  endtask

  task automatic open_file();
    longint unsigned raw, nblk, idat_len;
    byte unsigned sig[8] = '{137, 80, 78, 71, 13, 10, 26, 10};
    dim_w = clamp_dim(reg_w);
    dim_h = clamp_dim(reg_h);
    raw = longint'(dim_h) * (1 + 4 * longint'(dim_w));
    nblk = (raw + BlkMax - 1) / BlkMax;
    idat_len = 2 + 5 * nblk + raw + 4;
    foreach (sig[i]) emit(sig[i], 0);
    emit32(IHDR_LEN, 0);
    crc_acc = '1;
    emit32(TAG_IHDR, 1);
    emit32(dim_w, 1);
    emit32(dim_h, 1);
    emit(BIT_DEPTH, 1);
    emit(COLOR_TYPE, 1);
    emit(8'd0, 1); emit(8'd0, 1); emit(8'd0, 1);
    emit_crc();
    emit32(idat_len[31:0], 0);
    emit32(TAG_IDAT, 1);
    emit(ZLIB_CMF, 1);
    emit(ZLIB_FLG, 1);
    raw_left = raw; blk_left = 0; row_cnt = 0; row_bytes = 0;
    adl_lo = 1; adl_hi = 0;
    enc_phase = ENC_STREAM;
  endtask

  task automatic encode_byte(input logic [7:0] b);
    step_q.delete();
    if (enc_phase == ENC_DONE) return;
    if (enc_phase == ENC_IDLE) open_file();
    if (row_bytes == 0) emit_raw(8'd0);
    emit_raw(b);
    row_bytes++;
    if (row_bytes >= 4 * dim_w) begin
      row_bytes = 0;
      row_cnt++;
      if (row_cnt >= dim_h) begin
        emit32({adl_hi[15:0], adl_lo[15:0]}, 1);
        emit_crc();
        emit32(32'd0, 0);
        emit32(TAG_IEND, 1);
        emit_crc();
        step_q[$].fin = 1;
        enc_phase = ENC_DONE;
      end
    end
    if (step_q.size() > 0) step_q[$].last = 1;
    foreach (step_q[i]) file_q = {file_q, step_q[i]};
  endtask

  // idling profile follows progress through the stimulus
  always_comb begin
    case ((n_in * 4) / n_total)
      0: begin tx_idle = 0; rx_idle = 0; end
      1: begin tx_idle = 75; rx_idle = 0; end
      2: begin tx_idle = 0; rx_idle = 75; end
      default: begin tx_idle = 27; rx_idle = 27; end
    endcase
  end

  // pixel driver
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      encode_byte(pixel_byte_i);
      n_in++;
    end
    if (!in_valid_i || !in_stall_o) begin
      if (feed_en && pend_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
        in_valid_i <= 1'b1;
        pixel_byte_i <= pend_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    png_beat_t e;
    if (out_valid_o && !out_stall_i) begin
      n_out++;
      if (file_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected beat byte=%0h last=%0b end=%0b",
                                  out_byte_o, run_last_o, file_end_o);
      end else begin
        e = file_q.pop_front();
        if (e.data !== out_byte_o || e.last !== run_last_o || e.fin !== file_end_o) begin
          n_bad++;
          if (n_bad <= 10)
            $display("beat %0d: expected %0h/%0b/%0b, got %0h/%0b/%0b", n_out,
                     e.data, e.last, e.fin, out_byte_o, run_last_o, file_end_o);
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    // hold off long enough for the input side to back up
    if (rx_idle == 75 && !held) begin
      held = 1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cnt <= 0;
    else if (idle_cnt >= 3000) begin
      $display("watchdog expired: %0d beats still expected", file_q.size());
      $display("png_stored_block_encoder: mismatch");
      $finish;
    end else
      idle_cnt <= idle_cnt + 1;
  end

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [DIM_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_IMAGE_WIDTH) reg_w = val;
    else if (idx == CFG_IMAGE_HEIGHT) reg_h = val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pend_q.size() == 0 && !in_valid_i && file_q.size() == 0);
    repeat (100) @(posedge clk_i);
  endtask

  initial begin
    int unsigned h;
    byte unsigned dir[12] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE,
                              8'h0F, 8'hF0, 8'hFF, 8'h00};
    enc_phase = ENC_IDLE;
    reg_w = 1; reg_h = 1; dim_w = 1; dim_h = 1;
    crc_acc = '1; adl_lo = 1; adl_hi = 0;
    row_cnt = 0; row_bytes = 0; blk_left = 0; raw_left = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // large values first, then the image size that gets latched (width 0 clamps to 1)
    write_reg(CFG_IMAGE_WIDTH, 14'd16383);
    write_reg(CFG_IMAGE_HEIGHT, 14'd8192);
    h = $urandom_range(60, 66);
    write_reg(CFG_IMAGE_WIDTH, 14'd0);
    write_reg(CFG_IMAGE_HEIGHT, h[DIM_W-1:0]);
    foreach (dir[i]) pend_q = {pend_q, dir[i]};
    while (pend_q.size() < 4 * h + 30) pend_q = {pend_q, 8'($urandom_range(255))};
    n_total = pend_q.size() + 10;
    feed_en = 1;
    drain();
    // writes after the file: latched size must not change
    write_reg(CFG_IMAGE_WIDTH, 14'd8192);
    write_reg(CFG_IMAGE_HEIGHT, 14'd0);
    write_reg(CFG_IMAGE_WIDTH, 14'd1);
    for (int i = 0; i < 10; i++) pend_q = {pend_q, 8'($urandom_range(255))};
    drain();
    $display("%0d pixel bytes in, %0d file bytes out, %0d x %0d image, %0d mismatches",
             n_in, n_out, dim_w, dim_h, n_bad);
    if (n_bad == 0 && file_q.size() == 0)
      $display("png_stored_block_encoder: match");
    else
      $display("png_stored_block_encoder: mismatch");
    $finish;
  end

endmodule
